// File: src/tms_pkg.sv
package tms_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int FIFO_DEPTH           = 2;

    // point slots held for one triangle
    localparam logic [2:0] PT_A  = 3'd0;
    localparam logic [2:0] PT_B  = 3'd1;
    localparam logic [2:0] PT_C  = 3'd2;
    localparam logic [2:0] PT_AB = 3'd3;
    localparam logic [2:0] PT_BC = 3'd4;
    localparam logic [2:0] PT_CA = 3'd5;

    localparam logic [1:0] LAST_SUB    = 2'd3;
    localparam logic [1:0] LAST_CORNER = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nrm_stat_t;

    // point slot for a corner of a sub-triangle
    function automatic logic [2:0] tri_pt(input logic [1:0] s, input logic [1:0] k);
        logic [2:0] idx;
        idx = PT_A;
        unique case ({s, k})
            4'b0000: idx = PT_A;
            4'b0001: idx = PT_AB;
            4'b0010: idx = PT_CA;
            4'b0100: idx = PT_B;
            4'b0101: idx = PT_BC;
            4'b0110: idx = PT_AB;
            4'b1000: idx = PT_C;
            4'b1001: idx = PT_CA;
            4'b1010: idx = PT_BC;
            4'b1100: idx = PT_AB;
            4'b1101: idx = PT_BC;
            4'b1110: idx = PT_CA;
            default: idx = PT_A;
        endcase
        return idx;
    endfunction

endpackage

// File: src/triangle_midpoint_subdivider.sv
// channel    signals                                  transfer
// ---------  ---------------------------------------  -------------------------------
// input      corner_{a,b,c}_{x,y,z}                   start high while busy low
// result     vert_*, norm_*, sub_index, corner_index,  strobe high, one cycle each
//            last
//
// each triangle gives twelve results; a two-entry queue lets a new transaction
// be taken while the previous one is still being worked off.
// per sub-triangle: launch, cross product, sum of squares, one square-root digit
// per cycle, one quotient bit per divide step, done and three emits; plus one
// queue check per triangle. reset is asynchronous and clears the control state.
// the receiver cannot stall; busy is high only while the queue is full.
module triangle_midpoint_subdivider
    import tms_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [COORD_WIDTH-1:0]       corner_a_x,
    input  logic [COORD_WIDTH-1:0]       corner_a_y,
    input  logic [COORD_WIDTH-1:0]       corner_a_z,
    input  logic [COORD_WIDTH-1:0]       corner_b_x,
    input  logic [COORD_WIDTH-1:0]       corner_b_y,
    input  logic [COORD_WIDTH-1:0]       corner_b_z,
    input  logic [COORD_WIDTH-1:0]       corner_c_x,
    input  logic [COORD_WIDTH-1:0]       corner_c_y,
    input  logic [COORD_WIDTH-1:0]       corner_c_z,
    output logic                         strobe,
    output logic [COORD_WIDTH-1:0]       vert_x,
    output logic [COORD_WIDTH-1:0]       vert_y,
    output logic [COORD_WIDTH-1:0]       vert_z,
    output logic [NORMAL_FRAC_BITS+1:0]  norm_x,
    output logic [NORMAL_FRAC_BITS+1:0]  norm_y,
    output logic [NORMAL_FRAC_BITS+1:0]  norm_z,
    output logic [1:0]                   sub_index,
    output logic [1:0]                   corner_index,
    output logic                         last
);

    localparam int PTW = 18 * COORD_WIDTH;

    fifo_stat_t                          q_stat;
    logic                                push, pop;
    logic [5:0][2:0][COORD_WIDTH-1:0]    in_pts, head_pts;

    // accept and midpoint stage
    tms_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .corner_a_x (corner_a_x),
        .corner_a_y (corner_a_y),
        .corner_a_z (corner_a_z),
        .corner_b_x (corner_b_x),
        .corner_b_y (corner_b_y),
        .corner_b_z (corner_b_z),
        .corner_c_x (corner_c_x),
        .corner_c_y (corner_c_y),
        .corner_c_z (corner_c_z),
        .q_stat     (q_stat),
        .push       (push),
        .pts        (in_pts)
    );

    // triangle queue
    tms_fifo #(
        .W (PTW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_pts),
        .pop   (pop),
        .dout  (head_pts),
        .stat  (q_stat)
    );

    // normal computation and emission
    tms_back #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head         (head_pts),
        .pop          (pop),
        .strobe       (strobe),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vert_z       (vert_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .sub_index    (sub_index),
        .corner_index (corner_index),
        .last         (last)
    );

endmodule

// File: src/tms_fifo.sv
module tms_fifo
    import tms_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output fifo_stat_t   stat
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [W-1:0]  entry_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= din;
        end
    end

    // pointer and fill update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign dout       = entry_reg[rd_reg];
    assign stat.full  = (cnt_reg == CW'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// File: src/tms_front.sv
module tms_front
    import tms_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                 start,
    output logic                                 busy,
    input  logic [COORD_WIDTH-1:0]               corner_a_x,
    input  logic [COORD_WIDTH-1:0]               corner_a_y,
    input  logic [COORD_WIDTH-1:0]               corner_a_z,
    input  logic [COORD_WIDTH-1:0]               corner_b_x,
    input  logic [COORD_WIDTH-1:0]               corner_b_y,
    input  logic [COORD_WIDTH-1:0]               corner_b_z,
    input  logic [COORD_WIDTH-1:0]               corner_c_x,
    input  logic [COORD_WIDTH-1:0]               corner_c_y,
    input  logic [COORD_WIDTH-1:0]               corner_c_z,
    input  fifo_stat_t                           q_stat,
    output logic                                 push,
    output logic [5:0][2:0][COORD_WIDTH-1:0]     pts
);

    logic [2:0][COORD_WIDTH-1:0] ca, cb, cc;

    // midpoint with arithmetic halving
    function automatic logic [COORD_WIDTH-1:0] midp(input logic [COORD_WIDTH-1:0] p,
                                                    input logic [COORD_WIDTH-1:0] q);
        logic [COORD_WIDTH:0] sum;
        sum = {p[COORD_WIDTH-1], p} + {q[COORD_WIDTH-1], q};
        return sum[COORD_WIDTH:1];
    endfunction

    assign ca = {corner_a_z, corner_a_y, corner_a_x};
    assign cb = {corner_b_z, corner_b_y, corner_b_x};
    assign cc = {corner_c_z, corner_c_y, corner_c_x};

    // accept a transaction whenever the queue has room
    assign busy = q_stat.full;
    assign push = start && !q_stat.full;

    always_comb
    begin
        pts[PT_A] = ca;
        pts[PT_B] = cb;
        pts[PT_C] = cc;
        for (int i = 0; i < 3; i++)
        begin
            pts[PT_AB][i] = midp(ca[i], cb[i]);
            pts[PT_BC][i] = midp(cb[i], cc[i]);
            pts[PT_CA][i] = midp(cc[i], ca[i]);
        end
    end

endmodule

// File: src/tms_normal.sv
module tms_normal
    import tms_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [2:0][COORD_WIDTH-1:0]               p0,
    input  logic [2:0][COORD_WIDTH-1:0]               p1,
    input  logic [2:0][COORD_WIDTH-1:0]               p2,
    output nrm_stat_t                                 stat,
    output logic [2:0][NORMAL_FRAC_BITS+1:0]          nrm
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int CPW  = 2 * DW + 1;
    localparam int SW   = 2 * CPW;
    localparam int RW   = CPW;
    localparam int QW   = NORMAL_FRAC_BITS + 1;
    localparam int NOW  = NORMAL_FRAC_BITS + 2;
    localparam int MAXS = (RW > QW) ? RW : QW;
    localparam int CNW  = $clog2(MAXS + 1);

    typedef enum logic [7:0] {
        N_IDLE  = 8'b0000_0001,
        N_PROD  = 8'b0000_0010,
        N_CROSS = 8'b0000_0100,
        N_SQ    = 8'b0000_1000,
        N_SUM   = 8'b0001_0000,
        N_ROOT  = 8'b0010_0000,
        N_DIV   = 8'b0100_0000,
        N_DONE  = 8'b1000_0000
    } nstate_t;

    nstate_t state_reg, state_next;
    logic [CNW-1:0] cnt_reg, cnt_next;

    logic signed [DW-1:0]    u_reg [3];
    logic signed [DW-1:0]    v_reg [3];
    logic signed [2*DW-1:0]  pr_reg [6];
    logic signed [CPW-1:0]   c_reg [3];
    logic [SW-1:0]           sq_reg [3];
    logic [SW-1:0]           rad_reg;
    logic [RW-1:0]           root_reg;
    logic [RW+1:0]           rem_reg;
    logic                    zero_reg;
    logic [CPW:0]            rd_reg [3];
    logic [QW-1:0]           q_reg [3];
    logic                    neg_reg [3];

    logic [RW+1:0]           rem_sh, trial;
    logic                    root_ge;
    logic [SW-1:0]           sum_w;

    // control sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            N_IDLE:  if (start) state_next = N_PROD;
            N_PROD:  state_next = N_CROSS;
            N_CROSS: state_next = N_SQ;
            N_SQ:    state_next = N_SUM;
            N_SUM:
            begin
                state_next = N_ROOT;
                cnt_next   = '0;
            end
            N_ROOT:
            begin
                if (cnt_reg == CNW'(RW - 1))
                begin
                    state_next = N_DIV;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            N_DIV:
            begin
                if (cnt_reg == CNW'(QW - 1))
                begin
                    state_next = N_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // one square root digit per cycle
    assign rem_sh  = {rem_reg[RW-1:0], rad_reg[SW-1:SW-2]};
    assign trial   = {root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);
    assign sum_w   = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == N_IDLE && start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= $signed({p1[i][COORD_WIDTH-1], p1[i]})
                          - $signed({p0[i][COORD_WIDTH-1], p0[i]});
                v_reg[i] <= $signed({p2[i][COORD_WIDTH-1], p2[i]})
                          - $signed({p0[i][COORD_WIDTH-1], p0[i]});
            end
        end
        if (state_reg == N_PROD)
        begin
            pr_reg[0] <= u_reg[1] * v_reg[2];
            pr_reg[1] <= u_reg[2] * v_reg[1];
            pr_reg[2] <= u_reg[2] * v_reg[0];
            pr_reg[3] <= u_reg[0] * v_reg[2];
            pr_reg[4] <= u_reg[0] * v_reg[1];
            pr_reg[5] <= u_reg[1] * v_reg[0];
        end
        if (state_reg == N_CROSS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= CPW'(pr_reg[2*i]) - CPW'(pr_reg[2*i+1]);
            end
        end
        if (state_reg == N_SQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SW'(c_reg[i] * c_reg[i]);
            end
        end
        if (state_reg == N_SUM)
        begin
            rad_reg  <= sum_w;
            zero_reg <= (sum_w == '0);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (state_reg == N_ROOT)
        begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RW-2:0], root_ge};
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= c_reg[i][CPW-1];
                rd_reg[i]  <= c_reg[i][CPW-1] ? {1'b0, CPW'(-c_reg[i])}
                                              : {1'b0, CPW'(c_reg[i])};
                q_reg[i]   <= '0;
            end
        end
        // three restoring divider lanes share the root
        if (state_reg == N_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rd_reg[i] >= {1'b0, root_reg})
                begin
                    rd_reg[i] <= {CPW'(rd_reg[i] - {1'b0, root_reg}), 1'b0};
                    q_reg[i]  <= {q_reg[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rd_reg[i] <= {rd_reg[i][CPW-1:0], 1'b0};
                    q_reg[i]  <= {q_reg[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // signed q1.14 result, zero for a degenerate face
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
            begin
                nrm[i] = '0;
            end
            else if (neg_reg[i])
            begin
                nrm[i] = NOW'(-{1'b0, q_reg[i]});
            end
            else
            begin
                nrm[i] = {1'b0, q_reg[i]};
            end
        end
    end

    assign stat.busy = (state_reg != N_IDLE);
    assign stat.done = (state_reg == N_DONE);

endmodule

// File: src/tms_back.sv
module tms_back
    import tms_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fifo_stat_t                            q_stat,
    input  logic [5:0][2:0][COORD_WIDTH-1:0]      head,
    output logic                                  pop,
    output logic                                  strobe,
    output logic [COORD_WIDTH-1:0]                vert_x,
    output logic [COORD_WIDTH-1:0]                vert_y,
    output logic [COORD_WIDTH-1:0]                vert_z,
    output logic [NORMAL_FRAC_BITS+1:0]           norm_x,
    output logic [NORMAL_FRAC_BITS+1:0]           norm_y,
    output logic [NORMAL_FRAC_BITS+1:0]           norm_z,
    output logic [1:0]                            sub_index,
    output logic [1:0]                            corner_index,
    output logic                                  last
);

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_LAUNCH = 4'b0010,
        B_NORM   = 4'b0100,
        B_EMIT   = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [1:0] sub_reg, sub_next, k_reg, k_next;
    logic       strobe_reg;
    logic       nstart;
    nrm_stat_t  n_stat;
    logic [2:0][NORMAL_FRAC_BITS+1:0] nrm;
    logic [2:0][COORD_WIDTH-1:0] vp;

    logic [COORD_WIDTH-1:0]        vx_reg, vy_reg, vz_reg;
    logic [NORMAL_FRAC_BITS+1:0]   nx_reg, ny_reg, nz_reg;
    logic [1:0]                    si_reg, ci_reg;
    logic                          last_reg;

    tms_normal #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_normal (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nstart),
        .p0    (head[tri_pt(sub_reg, 2'd0)]),
        .p1    (head[tri_pt(sub_reg, 2'd1)]),
        .p2    (head[tri_pt(sub_reg, 2'd2)]),
        .stat  (n_stat),
        .nrm   (nrm)
    );

    // sub-triangle sequencer
    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        k_next     = k_reg;
        nstart     = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = B_LAUNCH;
                end
            end
            B_LAUNCH:
            begin
                nstart     = 1'b1;
                state_next = B_NORM;
            end
            B_NORM:
            begin
                if (n_stat.done)
                begin
                    state_next = B_EMIT;
                    k_next     = '0;
                end
            end
            B_EMIT:
            begin
                if (k_reg == LAST_CORNER)
                begin
                    k_next = '0;
                    if (sub_reg == LAST_SUB)
                    begin
                        pop        = 1'b1;
                        sub_next   = '0;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        sub_next   = sub_reg + 1'b1;
                        state_next = B_LAUNCH;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            sub_reg    <= '0;
            k_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sub_reg    <= sub_next;
            k_reg      <= k_next;
            strobe_reg <= (state_reg == B_EMIT);
        end
    end

    assign vp = head[tri_pt(sub_reg, k_reg)];

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == B_EMIT)
        begin
            vx_reg   <= vp[0];
            vy_reg   <= vp[1];
            vz_reg   <= vp[2];
            nx_reg   <= nrm[0];
            ny_reg   <= nrm[1];
            nz_reg   <= nrm[2];
            si_reg   <= sub_reg;
            ci_reg   <= k_reg;
            last_reg <= (sub_reg == LAST_SUB) && (k_reg == LAST_CORNER);
        end
    end

    assign strobe       = strobe_reg;
    assign vert_x       = vx_reg;
    assign vert_y       = vy_reg;
    assign vert_z       = vz_reg;
    assign norm_x       = nx_reg;
    assign norm_y       = ny_reg;
    assign norm_z       = nz_reg;
    assign sub_index    = si_reg;
    assign corner_index = ci_reg;
    assign last         = last_reg;

endmodule
